### design/slx_pkg.sv
// Shared types and constants for the shell command lexer.
// Holds the word structs, lexer mode and token kind codes, and queue sizing.
// No dependencies.
package slx_pkg;

  // Byte values that the lexer treats specially.
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // One input word gives rise to at most this many result words.
  localparam int unsigned MAX_RES  = 2;
  localparam int unsigned Q_DEPTH  = 8;
  localparam int unsigned Q_AW     = $clog2(Q_DEPTH);
  localparam int unsigned RES_CW   = $clog2(MAX_RES + 1);

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_WORD  = 2'd1,
    MODE_QUOTE = 2'd2,
    MODE_OPER  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    KIND_WORD      = 3'd0,
    KIND_OPERAND   = 3'd1,
    KIND_PIPE      = 3'd2,
    KIND_REDIRECT  = 3'd3,
    KIND_SUB_START = 3'd4,
    KIND_SUB_END   = 3'd5,
    KIND_EOF       = 3'd6,
    KIND_UNCLOSED  = 3'd7
  } kind_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic [7:0] token_byte;
    logic       byte_valid;
    kind_t      token_kind;
    logic       token_last;
  } out_word_t;

  // Results of one accepted input word, handed from the front to the queue.
  typedef struct packed {
    logic [RES_CW-1:0] cnt;
    out_word_t         d0;
    out_word_t         d1;
  } push_t;

  // Head of the queue as seen by the back end.
  typedef struct packed {
    logic      valid;
    out_word_t data;
  } q_head_t;

endpackage

### design/slx_front.sv
// Front end of the shell command lexer: accepts input words, tracks the
// lexer mode and classifies each byte into zero to two result words.
// Depends on slx_pkg.
module slx_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  slx_pkg::in_word_t in_word,
  output slx_pkg::push_t    push
);
  import slx_pkg::*;

  mode_t      mode_r, mode_nxt;
  logic       qdbl_r, qdbl_nxt;
  logic       esc_r, esc_nxt;
  logic [7:0] held_r, held_nxt;
  logic       hv_r, hv_nxt;

  logic [7:0] c;
  logic       is_blank, is_op, is_paren, is_quote, is_special;
  mode_t      eff_mode;

  // Effect of starting a token from idle with byte c.
  mode_t      s_mode;
  logic       s_hv, s_esc, s_qwr, s_emit;
  logic [7:0] s_held;
  out_word_t  s_item;

  out_word_t         r0, r1;
  logic [RES_CW-1:0] n;
  kind_t             single_kind, pair_kind;
  logic              merge;

  assign c          = in_word.text_byte;
  assign is_blank   = (c inside {CH_SPACE, [CH_TAB:CH_CR]});
  assign is_op      = (c inside {CH_PIPE, CH_AMP, CH_SEMI, CH_LT, CH_GT});
  assign is_paren   = (c inside {CH_LPAREN, CH_RPAREN});
  assign is_quote   = (c inside {CH_SQUOTE, CH_DQUOTE});
  assign is_special = is_quote || is_op || is_paren || (c == CH_BSLASH);

  always_comb begin
    s_mode        = MODE_IDLE;
    s_hv          = 1'b0;
    s_esc         = 1'b0;
    s_qwr         = 1'b0;
    s_emit        = 1'b0;
    s_held        = 8'h00;
    s_item        = '0;
    if (is_blank) begin
      s_mode = MODE_IDLE;
    end else if (is_op) begin
      s_mode = MODE_OPER;
      s_hv   = 1'b1;
      s_held = c;
    end else if (is_paren) begin
      s_emit            = 1'b1;
      s_item.token_byte = c;
      s_item.byte_valid = 1'b1;
      s_item.token_kind = (c == CH_LPAREN) ? KIND_SUB_START : KIND_SUB_END;
      s_item.token_last = 1'b1;
    end else if (is_quote) begin
      s_mode = MODE_QUOTE;
      s_hv   = 1'b1;
      s_held = c;
      s_qwr  = 1'b1;
    end else begin
      s_mode = MODE_WORD;
      s_hv   = 1'b1;
      s_held = c;
      s_esc  = (c == CH_BSLASH);
    end
  end

  always_comb begin
    if (held_r inside {CH_LT, CH_GT}) begin
      single_kind = KIND_REDIRECT;
    end else if (held_r == CH_PIPE) begin
      single_kind = KIND_PIPE;
    end else begin
      single_kind = KIND_OPERAND;
    end
    pair_kind = (held_r == CH_GT) ? KIND_REDIRECT : KIND_OPERAND;
    merge = (c == held_r) && (held_r inside {CH_PIPE, CH_AMP, CH_GT});
  end

  always_comb begin
    mode_nxt = mode_r;
    qdbl_nxt = qdbl_r;
    esc_nxt  = esc_r;
    held_nxt = held_r;
    hv_nxt   = hv_r;
    r0       = '0;
    r1       = '0;
    n        = '0;
    eff_mode = (!hv_r && mode_r != MODE_IDLE) ? MODE_IDLE : mode_r;

    if (in_word.end_of_text) begin
      r0.token_kind = KIND_EOF;
      r0.token_last = 1'b1;
      r1            = r0;
      n             = RES_CW'(2);
      if (mode_r == MODE_WORD && hv_r) begin
        r0.token_byte = held_r;
        r0.byte_valid = 1'b1;
        r0.token_kind = KIND_WORD;
      end else if (mode_r == MODE_OPER && hv_r) begin
        r0.token_byte = held_r;
        r0.byte_valid = 1'b1;
        r0.token_kind = single_kind;
      end else if (mode_r == MODE_QUOTE) begin
        r0.token_kind = KIND_UNCLOSED;
      end else begin
        n = RES_CW'(1);
      end
      mode_nxt = MODE_IDLE;
      qdbl_nxt = 1'b0;
      esc_nxt  = 1'b0;
      held_nxt = 8'h00;
      hv_nxt   = 1'b0;
    end else begin
      case (eff_mode)
        MODE_OPER: begin
          r0.token_byte = held_r;
          r0.byte_valid = 1'b1;
          if (merge) begin
            r0.token_kind = pair_kind;
            r1.token_byte = c;
            r1.byte_valid = 1'b1;
            r1.token_kind = pair_kind;
            r1.token_last = 1'b1;
            n             = RES_CW'(2);
            mode_nxt      = MODE_IDLE;
            esc_nxt       = 1'b0;
            held_nxt      = 8'h00;
            hv_nxt        = 1'b0;
          end else begin
            r0.token_kind = single_kind;
            r0.token_last = 1'b1;
            r1            = s_item;
            n             = s_emit ? RES_CW'(2) : RES_CW'(1);
            mode_nxt      = s_mode;
            esc_nxt       = s_esc;
            held_nxt      = s_held;
            hv_nxt        = s_hv;
            if (s_qwr) begin
              qdbl_nxt = (c == CH_DQUOTE);
            end
          end
        end
        MODE_QUOTE: begin
          r0.token_byte = held_r;
          r0.byte_valid = 1'b1;
          r0.token_kind = KIND_WORD;
          n             = RES_CW'(1);
          held_nxt      = c;
          esc_nxt       = 1'b0;
          if (c == (qdbl_r ? CH_DQUOTE : CH_SQUOTE)) begin
            mode_nxt = MODE_WORD;
          end
        end
        MODE_WORD: begin
          r0.token_byte = held_r;
          r0.byte_valid = 1'b1;
          r0.token_kind = KIND_WORD;
          n             = RES_CW'(1);
          if (esc_r && is_special) begin
            // An escaped special byte is taken literally into the word.
            held_nxt = c;
            esc_nxt  = 1'b0;
          end else if (is_blank || is_op || is_paren) begin
            r0.token_last = 1'b1;
            r1            = s_item;
            n             = s_emit ? RES_CW'(2) : RES_CW'(1);
            mode_nxt      = s_mode;
            esc_nxt       = s_esc;
            held_nxt      = s_held;
            hv_nxt        = s_hv;
            if (s_qwr) begin
              qdbl_nxt = (c == CH_DQUOTE);
            end
          end else begin
            held_nxt = c;
            if (is_quote) begin
              mode_nxt = MODE_QUOTE;
              qdbl_nxt = (c == CH_DQUOTE);
              esc_nxt  = 1'b0;
            end else begin
              esc_nxt = (c == CH_BSLASH);
            end
          end
        end
        default: begin
          r0       = s_item;
          n        = s_emit ? RES_CW'(1) : RES_CW'(0);
          mode_nxt = s_mode;
          esc_nxt  = s_esc;
          held_nxt = s_held;
          hv_nxt   = s_hv;
          if (s_qwr) begin
            qdbl_nxt = (c == CH_DQUOTE);
          end
        end
      endcase
    end

    push.cnt = fire ? n : '0;
    push.d0  = r0;
    push.d1  = r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      qdbl_r <= 1'b0;
      esc_r  <= 1'b0;
      held_r <= 8'h00;
      hv_r   <= 1'b0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      qdbl_r <= qdbl_nxt;
      esc_r  <= esc_nxt;
      held_r <= held_nxt;
      hv_r   <= hv_nxt;
    end
  end

endmodule

### design/slx_queue.sv
// Result queue of the shell command lexer: takes up to two words per cycle
// from the front end and releases one per cycle to the back end when it pops.
// Depends on slx_pkg.
module slx_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  slx_pkg::push_t   push,
  input  logic             pop,
  output slx_pkg::q_head_t head,
  output logic             full
);
  import slx_pkg::*;

  out_word_t       mem [Q_DEPTH];
  logic [Q_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [Q_AW:0]   cnt_r, cnt_nxt;
  logic [Q_AW-1:0] wp1;

  assign wp1       = wp_r + Q_AW'(1);
  assign head.valid = (cnt_r != '0);
  assign head.data  = mem[rp_r];
  // Room for a full burst of results must stay free before a word is taken.
  assign full      = (cnt_r > (Q_AW+1)'(Q_DEPTH - MAX_RES));

  always_comb begin
    wp_nxt  = wp_r + Q_AW'(push.cnt);
    rp_nxt  = rp_r + (pop ? Q_AW'(1) : Q_AW'(0));
    cnt_nxt = cnt_r + (Q_AW+1)'(push.cnt) - (pop ? (Q_AW+1)'(1) : (Q_AW+1)'(0));
  end

  always_ff @(posedge clk) begin
    if (push.cnt != '0) begin
      mem[wp_r] <= push.d0;
    end
    if (push.cnt == RES_CW'(2)) begin
      mem[wp1] <= push.d1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### design/slx_back.sv
// Back end of the shell command lexer: moves queue words into the output
// register and holds them while the receiver stalls.
// Depends on slx_pkg.
module slx_back (
  input  logic               clk,
  input  logic               rst_n,
  input  slx_pkg::q_head_t   head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output slx_pkg::out_word_t out_word
);
  import slx_pkg::*;

  logic      valid_r, valid_nxt;
  out_word_t word_r;

  assign pop       = head.valid && (!valid_r || !out_stall);
  assign valid_nxt = pop || (valid_r && out_stall);
  assign out_valid = valid_r;
  assign out_word  = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      word_r <= head.data;
    end
  end

endmodule

### design/shell_command_lexer.sv
// Top level of the shell command lexer: front end, result queue, back end.
// Depends on slx_pkg, slx_front, slx_queue and slx_back.
//
// Usage: the sender offers one command-line byte per input word on
// in_valid/in_word; a word is taken at a rising edge with in_valid high and
// in_stall low. A word with end_of_text set flushes the open token and yields
// an EOF marker (preceded by an unclosed-quote marker inside quotes).
// Result words appear on out_valid/out_word and are taken at an edge with
// out_valid high and out_stall low.
// Throughput: one input word per cycle while in_stall is low. Each input
// word yields zero to two result words, and the single output register
// releases one per cycle while out_stall is low, so the output port sets
// the long-run rate when bursts of results arrive. A result is written
// to the queue as its input word is taken, then to the output register.
// Each token byte is held one word back so its last byte can be marked.
// When the receiver stalls, the output word holds, the eight-entry queue
// fills, and in_stall rises once fewer than two entries are free.
// Reset (rst_n low at a clock edge) returns the lexer to idle between
// tokens and empties the queue and output register.
module shell_command_lexer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  slx_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output slx_pkg::out_word_t out_word
);
  import slx_pkg::*;

  logic    fire;
  logic    pop;
  logic    full;
  push_t   push;
  q_head_t head;

  // The input side stalls only on a nearly full queue, never on the output.
  assign in_stall = full;
  assign fire     = in_valid && !in_stall;

  slx_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .in_word (in_word),
    .push    (push)
  );

  slx_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .full  (full)
  );

  slx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

`ifndef SYNTH
  // Nothing is pushed into the queue unless an input word was taken.
  a_no_push_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_stall || !in_valid) |-> (push.cnt == '0))
    else $error("results pushed without an accepted input word");

  // Every accepted end word pushes at least its EOF marker.
  a_end_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_word.end_of_text) |-> (push.cnt != '0))
    else $error("end of text accepted without an EOF result");

  // The back end never pops an empty queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("pop from an empty result queue");

  // A popped word reaches the output register at the next edge.
  a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid)
    else $error("popped result did not reach the output");
`endif

endmodule
